// ===== hw/rtl/amt_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the affine
// matrix block. No dependencies.
`default_nettype none

package amt_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SCALE_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 32;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
  };

  localparam int KW          = 26;
  localparam int KW1         = KW + 1;
  localparam int SUM_W       = 60;
  localparam int COEF_W      = 16;
  localparam int TRANS_W     = 32;
  localparam int COEF_SHIFT  = 8;
  localparam int FRAC_SHIFT  = 16;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } amt_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_a;
    logic signed [COEF_W-1:0]  coef_b;
    logic signed [COEF_W-1:0]  coef_c;
    logic signed [COEF_W-1:0]  coef_d;
    logic signed [TRANS_W-1:0] trans_x;
    logic signed [TRANS_W-1:0] trans_y;
  } amt_res_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } amt_side_t;

  typedef struct packed {
    logic signed [KW-1:0]    kxc;
    logic signed [KW-1:0]    kxs;
    logic signed [KW-1:0]    kyc;
    logic signed [KW-1:0]    kys;
    logic signed [SUM_W-1:0] tx;
    logic signed [SUM_W-1:0] ty;
  } amt_mid_t;

endpackage

`default_nettype wire

// ===== hw/rtl/amt_cordic.sv =====
// Pipelined rotation-mode CORDIC: one step per stage, gives cosine and sine
// at SCALE_BITS fraction bits. Depends on amt_pkg.
`default_nettype none

module amt_cordic
  import amt_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  amt_item_t                   in_item,
  output logic                        out_vld,
  output logic signed [SCALE_BITS+2:0] out_cos,
  output logic signed [SCALE_BITS+2:0] out_sin,
  output amt_side_t                   out_side
);

  localparam int N   = CORDIC_STEPS;
  localparam int TW  = SCALE_BITS + 3;
  localparam int EW  = 35;
  localparam int RSH = (SCALE_BITS < 30) ? 30 - SCALE_BITS : 0;
  localparam int LSH = (SCALE_BITS > 30) ? SCALE_BITS - 30 : 0;
  localparam logic signed [EW-1:0] RND = EW'((64'd1 << RSH) >> 1);
  localparam logic signed [CW-1:0] QUARTER     = 32'sh40000000;
  localparam logic signed [CW-1:0] NEG_QUARTER = -QUARTER;
  localparam logic signed [CW-1:0] RES_LIM     = 32'sd128;

  logic [ANGLE_BITS-1:0] ang;
  logic signed [CW-1:0]  z_raw;
  logic signed [CW-1:0]  z_fold;
  logic                  fold;

  logic                 vld  [0:N];
  logic signed [CW-1:0] x    [0:N];
  logic signed [CW-1:0] y    [0:N];
  logic signed [CW-1:0] z    [0:N];
  logic                 flip [0:N];
  amt_side_t            side [0:N];

  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  logic signed [EW-1:0] xr;
  logic signed [EW-1:0] yr;

  // fold the angle into [-1/4, 1/4] turn
  always_comb begin
    ang    = ANGLE_BITS'(in_item.angle);
    z_raw  = {ang, {(CW-ANGLE_BITS){1'b0}}};
    fold   = (z_raw > QUARTER) || (z_raw < NEG_QUARTER);
    z_fold = fold ? {~z_raw[CW-1], z_raw[CW-2:0]} : z_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        vld[i] <= 1'b0;
      end
      out_vld <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int i = 0; i < N; i++) begin
        vld[i+1] <= vld[i];
      end
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    x[0]    <= CORDIC_GAIN;
    y[0]    <= '0;
    z[0]    <= z_fold;
    flip[0] <= fold;
    side[0] <= '{pos_x: in_item.pos_x, pos_y: in_item.pos_y,
                 scale_x: in_item.scale_x, scale_y: in_item.scale_y,
                 origin_x: in_item.origin_x, origin_y: in_item.origin_y};
    for (int i = 0; i < N; i++) begin
      if (!z[i][CW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN_TURNS[i];
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN_TURNS[i];
      end
      flip[i+1] <= flip[i];
      side[i+1] <= side[i];
    end
  end

  // undo the fold, rescale to SCALE_BITS
  always_comb begin
    xf = flip[N] ? -x[N] : x[N];
    yf = flip[N] ? -y[N] : y[N];
    xr = ((EW'(xf) + RND) >>> RSH) <<< LSH;
    yr = ((EW'(yf) + RND) >>> RSH) <<< LSH;
  end

  always_ff @(posedge clk) begin
    out_cos  <= xr[TW-1:0];
    out_sin  <= yr[TW-1:0];
    out_side <= side[N];
  end

`ifndef SYNTHESIS
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (z[0] <= QUARTER) && (z[0] >= NEG_QUARTER))
    else $error("folded angle outside a quarter turn");

  a_residual: assert property (@(posedge clk) disable iff (rst)
    vld[N] |-> (z[N] < RES_LIM) && (z[N] > -RES_LIM))
    else $error("CORDIC residual angle did not converge");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/amt_mul.sv =====
// Multiply stages: scale times trig, rounding to Q10.16, origin products and
// translation sums. Depends on amt_pkg.
`default_nettype none

module amt_mul
  import amt_pkg::*;
#(
  parameter int SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic signed [SCALE_BITS+2:0] in_cos,
  input  logic signed [SCALE_BITS+2:0] in_sin,
  input  amt_side_t                    in_side,
  output logic                         out_vld,
  output amt_mid_t                     out_mid
);

  localparam int TW  = SCALE_BITS + 3;
  localparam int PW  = TW + 16;
  localparam int PW1 = PW + 1;
  localparam int QW  = 32 + KW;
  localparam int KSH = SCALE_BITS - 8;
  localparam logic signed [PW:0] KRND = PW1'((64'd1 << KSH) >> 1);

  logic [2:0] vld;

  logic signed [PW-1:0] p_xc, p_xs, p_yc, p_ys;
  amt_side_t            side1;

  logic signed [KW-1:0] k2_xc, k2_xs, k2_yc, k2_ys;
  amt_side_t            side2;

  logic signed [QW-1:0] q_xc, q_ys, q_xs, q_yc;
  logic signed [KW-1:0] k3_xc, k3_xs, k3_yc, k3_ys;
  logic signed [31:0]   px3, py3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[1:0], in_vld};
      out_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    p_xc  <= $signed(in_side.scale_x) * in_cos;
    p_xs  <= $signed(in_side.scale_x) * in_sin;
    p_yc  <= $signed(in_side.scale_y) * in_cos;
    p_ys  <= $signed(in_side.scale_y) * in_sin;
    side1 <= in_side;

    k2_xc <= KW'((PW1'(p_xc) + KRND) >>> KSH);
    k2_xs <= KW'((PW1'(p_xs) + KRND) >>> KSH);
    k2_yc <= KW'((PW1'(p_yc) + KRND) >>> KSH);
    k2_ys <= KW'((PW1'(p_ys) + KRND) >>> KSH);
    side2 <= side1;

    q_xc  <= $signed(side2.origin_x) * k2_xc;
    q_ys  <= $signed(side2.origin_y) * k2_ys;
    q_xs  <= $signed(side2.origin_x) * k2_xs;
    q_yc  <= $signed(side2.origin_y) * k2_yc;
    k3_xc <= k2_xc;
    k3_xs <= k2_xs;
    k3_yc <= k2_yc;
    k3_ys <= k2_ys;
    px3   <= side2.pos_x;
    py3   <= side2.pos_y;

    out_mid.kxc <= k3_xc;
    out_mid.kxs <= k3_xs;
    out_mid.kyc <= k3_yc;
    out_mid.kys <= k3_ys;
    out_mid.tx  <= -SUM_W'(q_xc) - SUM_W'(q_ys) + (SUM_W'(px3) <<< FRAC_SHIFT);
    out_mid.ty  <= SUM_W'(q_xs) - SUM_W'(q_yc) + (SUM_W'(py3) <<< FRAC_SHIFT);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/amt_round.sv =====
// Output stage: round half up and saturate coefficients and translations
// into the result register. Depends on amt_pkg.
`default_nettype none

module amt_round
  import amt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_vld,
  input  amt_mid_t in_mid,
  output logic     done,
  output amt_res_t result
);

  localparam logic signed [KW:0]       C_RND = KW1'(128);
  localparam logic signed [KW:0]       C_MAX = KW1'(32767);
  localparam logic signed [KW:0]       C_MIN = -C_MAX - KW1'(1);
  localparam logic signed [SUM_W-1:0]  T_RND = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0]  T_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0]  T_MIN = -T_MAX - SUM_W'(1);

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [KW:0] v);
    logic signed [KW:0] r;
    r = (v + C_RND) >>> COEF_SHIFT;
    if (r > C_MAX) begin
      return C_MAX[COEF_W-1:0];
    end else if (r < C_MIN) begin
      return C_MIN[COEF_W-1:0];
    end
    return r[COEF_W-1:0];
  endfunction

  function automatic logic signed [TRANS_W-1:0] sat_trans(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + T_RND) >>> FRAC_SHIFT;
    if (r > T_MAX) begin
      return T_MAX[TRANS_W-1:0];
    end else if (r < T_MIN) begin
      return T_MIN[TRANS_W-1:0];
    end
    return r[TRANS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.coef_a  <= sat_coef(KW1'(in_mid.kxc));
    result.coef_b  <= sat_coef(KW1'(in_mid.kys));
    result.coef_c  <= sat_coef(-KW1'(in_mid.kxs));
    result.coef_d  <= sat_coef(KW1'(in_mid.kyc));
    result.trans_x <= sat_trans(in_mid.tx);
    result.trans_y <= sat_trans(in_mid.ty);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/affine_matrix_from_trs.sv =====
// Top level: 2D affine matrix from position, angle, scale and origin.
// Depends on amt_pkg, amt_cordic, amt_mul and amt_round.
//
//   channel   handshake        payload     direction
//   command   start / busy     item        in
//   result    done (strobe)    result      out
//
// One item enters per clock while busy is low. From accept to done an item
// passes the fold, the 30 CORDIC step stages, the rescale, four
// multiply/add stages and the output register.
// busy is high only during reset; reset clears the valid bits, not the data.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module affine_matrix_from_trs
  import amt_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  amt_item_t item,
  output logic      done,
  output amt_res_t  result
);

  localparam int LATENCY = CORDIC_STEPS + 7;

  logic                         accept;
  logic                         trig_vld;
  logic signed [SCALE_BITS+2:0] trig_cos;
  logic signed [SCALE_BITS+2:0] trig_sin;
  amt_side_t                    trig_side;
  logic                         mid_vld;
  amt_mid_t                     mid;

  assign busy   = rst;
  assign accept = start && !busy;

  amt_cordic #(
    .ANGLE_BITS(ANGLE_BITS),
    .SCALE_BITS(SCALE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .in_item  (item),
    .out_vld  (trig_vld),
    .out_cos  (trig_cos),
    .out_sin  (trig_sin),
    .out_side (trig_side)
  );

  amt_mul #(
    .SCALE_BITS(SCALE_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (trig_vld),
    .in_cos  (trig_cos),
    .in_sin  (trig_sin),
    .in_side (trig_side),
    .out_vld (mid_vld),
    .out_mid (mid)
  );

  amt_round u_round (
    .clk    (clk),
    .rst    (rst),
    .in_vld (mid_vld),
    .in_mid (mid),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item produced no result");

  a_done_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without an accepted item");
`endif

endmodule

`default_nettype wire
